// ===== rtl/ptsw_pkg.sv =====
// Shared types and constants of the pan/tilt scan waypoint generator.
package ptsw_pkg;

    localparam int DIV_W = 16;
    localparam int DIV_CNT_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [11:0] COL_SAT = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_MIN = 3'd5;

    typedef enum logic [2:0] {
        SEQ_ROWS,
        SEQ_COLS,
        SEQ_TSTEP,
        SEQ_PSTEP,
        SEQ_READY
    } seq_state_t;

endpackage

// ===== rtl/ptsw_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ptsw_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptsw_pkg::DIV_W-1:0]    dividend,
    input  logic [ptsw_pkg::DIV_W-1:0]    divisor,
    output logic                          done,
    output logic [ptsw_pkg::DIV_W-1:0]    quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ptsw_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [ptsw_pkg::DIV_W-1:0]        rem_reg;
    logic [ptsw_pkg::DIV_W-1:0]        quo_reg;
    logic [ptsw_pkg::DIV_W-1:0]        dvs_reg;
    logic [ptsw_pkg::DIV_W:0]          shifted;
    logic [ptsw_pkg::DIV_W:0]          trial;
    logic                              ge;

    assign shifted = {rem_reg, quo_reg[ptsw_pkg::DIV_W-1]};
    assign trial = shifted - {1'b0, dvs_reg};
    assign ge = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {ptsw_pkg::DIV_CNT_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[ptsw_pkg::DIV_W-1:0] : shifted[ptsw_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[ptsw_pkg::DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pan_tilt_scan_waypoint_generator_top.sv =====
// Top level of the pan/tilt scan waypoint generator.
//
// Input channel: point_index with in_valid/in_stall; an item is taken when
// in_valid is high and in_stall low. Output channel: pan_angle, tilt_angle,
// counts and flags with out_valid/out_stall.
// Configuration: cfg_write, cfg_index, cfg_data; one register per write.
// After reset and after every configuration write a sequencer derives the
// row and column counts and the tilt and pan steps with one shared serial
// divider in four divisions, during which in_stall is high. Configuration
// writes are taken at any time. Once derived, one item is taken per cycle
// while in_stall is low. An accepted item passes through the three register
// stages (side select, row offset multiply, tilt subtract into the output
// register) before out_valid. When the receiver stalls, the output register
// holds its item and the earlier stages keep filling bubbles; in_stall then
// rises only when all three stages are full. Reset clears all valid bits and
// restores the register reset values.
module pan_tilt_scan_waypoint_generator_top
#(
    parameter int MAX_ROWS = 31
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ptsw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptsw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [5:0]                            point_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [12:0]                    pan_angle,
    output logic signed [12:0]                    tilt_angle,
    output logic [5:0]                            point_count,
    output logic [4:0]                            row_count,
    output logic [11:0]                           column_count,
    output logic                                  index_ok,
    output logic                                  setup_error,
    output logic                                  count_clipped
);

    logic [11:0]         view_width_reg;
    logic [11:0]         view_height_reg;
    logic [11:0]         pan_limit_reg;
    logic signed [12:0]  tilt_low_reg;
    logic signed [12:0]  tilt_high_reg;
    logic [11:0]         overlap_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg <= 12'd600;
            view_height_reg <= 12'd800;
            pan_limit_reg <= 12'd1280;
            tilt_low_reg <= -13'sd80;
            tilt_high_reg <= 13'sd1520;
            overlap_min_reg <= 12'd80;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptsw_pkg::REG_VIEW_WIDTH:  view_width_reg <= cfg_data[11:0];
                ptsw_pkg::REG_VIEW_HEIGHT: view_height_reg <= cfg_data[11:0];
                ptsw_pkg::REG_PAN_LIMIT:   pan_limit_reg <= cfg_data[11:0];
                ptsw_pkg::REG_TILT_LOW:    tilt_low_reg <= $signed(cfg_data);
                ptsw_pkg::REG_TILT_HIGH:   tilt_high_reg <= $signed(cfg_data);
                ptsw_pkg::REG_OVERLAP_MIN: overlap_min_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] vw_s, vh_s, pl_s, ov_s, tl_s, th_s;
    logic signed [15:0] vw_half, vh_half;
    logic signed [15:0] t_miss, t_gain, p_miss, p_gain;
    logic signed [15:0] t_diff, p_end_full, p_diff;
    logic [15:0]        t_diff_mag, p_diff_mag;

    assign vw_s = $signed({4'b0, view_width_reg});
    assign vh_s = $signed({4'b0, view_height_reg});
    assign pl_s = $signed({4'b0, pan_limit_reg});
    assign ov_s = $signed({4'b0, overlap_min_reg});
    assign tl_s = 16'(tilt_low_reg);
    assign th_s = 16'(tilt_high_reg);
    assign vw_half = $signed({5'b0, view_width_reg[11:1]});
    assign vh_half = $signed({5'b0, view_height_reg[11:1]});
    assign t_miss = th_s - tl_s - vh_s;
    assign t_gain = vh_s - ov_s;
    assign p_miss = pl_s + pl_s - vw_s;
    assign p_gain = vw_s - ov_s;
    assign t_diff = (th_s - vh_half) - (tl_s + vh_half);
    assign p_end_full = pl_s - vw_half;
    assign p_diff = p_end_full + p_end_full;
    assign t_diff_mag = t_diff[15] ? 16'(-t_diff) : 16'(t_diff);
    assign p_diff_mag = p_diff[15] ? 16'(-p_diff) : 16'(p_diff);

    ptsw_pkg::seq_state_t   state_reg, state_next;
    logic                   start_reg, start_next;
    logic                   div_done, done_ok;
    logic [15:0]            quo;
    logic [15:0]            div_dividend, div_divisor;
    logic [4:0]             rows_reg;
    logic [11:0]            cols_reg;
    logic                   t_err_reg, p_err_reg, t_clip_reg, p_clip_reg;
    logic signed [15:0]     t_step_reg, p_step_reg;

    assign done_ok = div_done && !start_reg;

    always_comb
    begin
        state_next = state_reg;
        if (cfg_write)
        begin
            state_next = ptsw_pkg::SEQ_ROWS;
        end
        else if (done_ok)
        begin
            unique case (state_reg)
                ptsw_pkg::SEQ_ROWS:  state_next = ptsw_pkg::SEQ_COLS;
                ptsw_pkg::SEQ_COLS:  state_next = ptsw_pkg::SEQ_TSTEP;
                ptsw_pkg::SEQ_TSTEP: state_next = ptsw_pkg::SEQ_PSTEP;
                ptsw_pkg::SEQ_PSTEP: state_next = ptsw_pkg::SEQ_READY;
                default:             state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        start_next = cfg_write || (done_ok && state_reg != ptsw_pkg::SEQ_PSTEP
                                   && state_reg != ptsw_pkg::SEQ_READY);
        div_dividend = '0;
        div_divisor = '0;
        unique case (state_reg)
            ptsw_pkg::SEQ_ROWS:
            begin
                div_dividend = 16'(t_miss + t_gain - 16'sd1);
                div_divisor = 16'(t_gain);
            end
            ptsw_pkg::SEQ_COLS:
            begin
                div_dividend = 16'(p_miss + p_gain - 16'sd1);
                div_divisor = 16'(p_gain);
            end
            ptsw_pkg::SEQ_TSTEP:
            begin
                div_dividend = t_diff_mag;
                div_divisor = {11'b0, rows_reg - 5'd1};
            end
            ptsw_pkg::SEQ_PSTEP:
            begin
                div_dividend = p_diff_mag;
                div_divisor = {4'b0, cols_reg - 12'd1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptsw_pkg::SEQ_ROWS;
            start_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    ptsw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 5'd1;
            cols_reg <= 12'd1;
            t_err_reg <= 1'b0;
            p_err_reg <= 1'b0;
            t_clip_reg <= 1'b0;
            p_clip_reg <= 1'b0;
            t_step_reg <= '0;
            p_step_reg <= '0;
        end
        else if (done_ok)
        begin
            case (state_reg)
                ptsw_pkg::SEQ_ROWS:
                begin
                    t_err_reg <= 1'b0;
                    t_clip_reg <= 1'b0;
                    if (t_miss <= 16'sd0)
                    begin
                        rows_reg <= 5'd1;
                    end
                    else if (t_gain <= 16'sd0)
                    begin
                        rows_reg <= 5'd1;
                        t_err_reg <= 1'b1;
                    end
                    else if (quo >= 16'(MAX_ROWS))
                    begin
                        rows_reg <= 5'(MAX_ROWS);
                        t_clip_reg <= 1'b1;
                    end
                    else
                    begin
                        rows_reg <= quo[4:0] + 5'd1;
                    end
                end
                ptsw_pkg::SEQ_COLS:
                begin
                    p_err_reg <= 1'b0;
                    p_clip_reg <= 1'b0;
                    if (p_miss <= 16'sd0)
                    begin
                        cols_reg <= 12'd1;
                    end
                    else if (p_gain <= 16'sd0)
                    begin
                        cols_reg <= 12'd1;
                        p_err_reg <= 1'b1;
                    end
                    else if (quo >= {4'b0, ptsw_pkg::COL_SAT})
                    begin
                        cols_reg <= ptsw_pkg::COL_SAT;
                        p_clip_reg <= 1'b1;
                    end
                    else
                    begin
                        cols_reg <= quo[11:0] + 12'd1;
                    end
                end
                ptsw_pkg::SEQ_TSTEP:
                    t_step_reg <= t_diff[15] ? -$signed(quo) : $signed(quo);
                ptsw_pkg::SEQ_PSTEP:
                begin
                    if (cols_reg == 12'd1)
                    begin
                        p_step_reg <= '0;
                    end
                    else
                    begin
                        p_step_reg <= p_diff[15] ? -$signed(quo) : $signed(quo);
                    end
                end
                default: ;
            endcase
        end
    end

    logic signed [15:0] t_mid, t_start, t_end, p_start, p_end, p_end_short;
    logic [5:0]         npts;
    logic               one_row;

    assign one_row = (rows_reg == 5'd1);
    assign t_mid = (tl_s + th_s) >>> 1;
    assign t_start = one_row ? t_mid : (tl_s + vh_half);
    assign t_end = th_s - vh_half;
    assign p_end = (cols_reg == 12'd1) ? 16'sd0 : p_end_full;
    assign p_start = -p_end;
    assign p_end_short = p_end - p_step_reg;
    assign npts = one_row ? 6'd2 : ({rows_reg, 1'b0} + 6'd1);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = (state_reg != ptsw_pkg::SEQ_READY) || !en1;

    logic [4:0]         r_in;
    logic               close_in;
    logic signed [15:0] side_a, side_b, pan_in;

    assign r_in = point_index[5:1];
    assign close_in = (point_index >= {rows_reg, 1'b0});
    assign side_a = p_start;
    assign side_b = (r_in >= 5'd2) ? p_end_short : p_end;

    always_comb
    begin
        if (close_in)
        begin
            pan_in = rows_reg[0] ? p_end : p_start;
        end
        else
        begin
            pan_in = (r_in[0] ^ point_index[0]) ? side_b : side_a;
        end
    end

    logic signed [12:0] s1_pan_reg, s2_pan_reg;
    logic [4:0]         s1_r_reg;
    logic               s1_ok_reg, s1_close_reg;
    logic signed [21:0] s2_prod_reg;
    logic               s2_ok_reg, s2_first_reg;
    logic signed [22:0] tilt_full;

    assign tilt_full = 23'(t_end) - 23'(s2_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid && !in_stall;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pan_reg <= pan_in[12:0];
            s1_r_reg <= r_in;
            s1_ok_reg <= (point_index < npts);
            s1_close_reg <= close_in;
        end
        if (en2)
        begin
            s2_prod_reg <= 22'($signed({1'b0, s1_r_reg} - 6'd1) * t_step_reg);
            s2_pan_reg <= s1_pan_reg;
            s2_ok_reg <= s1_ok_reg;
            s2_first_reg <= (s1_r_reg == 5'd0) || s1_close_reg;
        end
        if (en3)
        begin
            pan_angle <= s2_ok_reg ? s2_pan_reg : 13'sd0;
            tilt_angle <= !s2_ok_reg ? 13'sd0
                        : (s2_first_reg ? t_start[12:0] : tilt_full[12:0]);
            index_ok <= s2_ok_reg;
            point_count <= npts;
            row_count <= rows_reg;
            column_count <= cols_reg;
            setup_error <= t_err_reg || p_err_reg;
            count_clipped <= t_clip_reg || p_clip_reg;
        end
    end

    assign out_valid = v3_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_ok |-> pan_angle == 13'sd0 && tilt_angle == 13'sd0)
        else $error("invalid index item carries a non-zero angle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_count == 5'd1 && point_count == 6'd2)
                   || (row_count != 5'd1 && point_count == {row_count, 1'b0} + 6'd1))
        else $error("point count disagrees with row count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> in_stall)
        else $error("item accepted before derivation restarted");
`endif

endmodule
